// ===== rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int CHAR_W     = 8;
   localparam int BYTE_W     = 8;
   localparam int SEXTET_W   = 6;
   localparam int ACC_W      = 18;
   localparam int STATUS_W   = 2;
   localparam int MAX_RES    = 3;
   localparam int RES_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W      = $clog2(QUEUE_DEPTH);

   // special character codes
   localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

   // offsets that move each alphabet range onto its sextet value
   localparam logic [CHAR_W-1:0] LO_OFFSET  = 8'd71;
   localparam logic [CHAR_W-1:0] DIG_OFFSET = 8'd4;
   localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 6'd62;
   localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_CHAR   = 2'd1,
      STATUS_BAD_LENGTH = 2'd2
   } status_type;

   typedef struct packed {
      logic                bad;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   // one accepted character's worth of results, waiting for the back end
   typedef struct packed {
      logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
      logic [RES_W-1:0]               nres;
      logic                           byte_valid;
      status_type                     last_status;
      logic                           done;
   } job_type;

   function automatic sextet_type sextet_of(input logic [CHAR_W-1:0] c);
      sextet_type r;
      r.bad   = 1'b0;
      r.value = '0;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         r.value = SEXTET_W'(c - CHAR_UP_A);
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         r.value = SEXTET_W'(c - LO_OFFSET);
      end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
         r.value = SEXTET_W'(c + DIG_OFFSET);
      end else if (c == CHAR_PLUS) begin
         r.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         r.value = SEXTET_SLASH;
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

// ===== rtl/b64d_req_if.sv =====
// ----------------------------------------------------------------------------
// b64d_req_if
// Character channel: one text character per item plus end-of-stream mark.
// ----------------------------------------------------------------------------
interface b64d_req_if
   import b64d_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              stream_end;

   modport source (output valid, output char_in, output stream_end, input ready);
   modport sink   (input valid, input char_in, input stream_end, output ready);
endinterface

// ===== rtl/b64d_rsp_if.sv =====
// ----------------------------------------------------------------------------
// b64d_rsp_if
// Result channel: one decoded byte or status item per transfer.
// ----------------------------------------------------------------------------
interface b64d_rsp_if
   import b64d_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic                byte_valid;
   logic [STATUS_W-1:0] status;
   logic                run_last;
   logic                stream_done;

   modport source (output valid, output data_byte, output byte_valid, output status,
                   output run_last, output stream_done, input ready);
   modport sink   (input valid, input data_byte, input byte_valid, input status,
                   input run_last, input stream_done, output ready);
endinterface

// ===== rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 decoder, standard alphabet, one character item in per cycle while the job queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one character per item with stream_end on the last one of
//   a stream. Whitespace is skipped; '=' ends the data part of a stream.
//   rsp_ch carries decoded bytes and status items; run_last marks the final
//   item caused by one character, stream_done the item with the final status.
//   An accepted character's job is written to the job queue, and its first
//   item then passes through the output register before it is valid.
//   One character per cycle unless the queue is full; a character causes up
//   to three items. The back end sends one item per cycle from a four-entry
//   job queue unless rsp_ch stalls; req_ch.ready drops only while the queue is full.
//   Reset clears the stream state, the queue and the output register.
//   A stalled receiver holds the output register; the queue keeps taking
//   characters until it fills.
// ----------------------------------------------------------------------------
module base64_stream_decoder
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_ch,
   b64d_rsp_if.source rsp_ch
);

   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   job_type push_job;
   job_type head;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (full),
      .push       (push),
      .job        (push_job)
   );

   b64d_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   b64d_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTHESIS
   // the stream's final item always closes its character's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.stream_done |-> rsp_ch.run_last)
      else $error("stream_done without run_last");

   // a status-only item is always the only item of its character
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.byte_valid |-> rsp_ch.run_last)
      else $error("status-only item not last");

   // items inside a run carry ok status
   a_mid_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.run_last |-> rsp_ch.status == STATUS_OK)
      else $error("non-last item with error status");

   // output is empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("output valid after reset");
`endif

endmodule

// ===== rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, packs sextets and builds result jobs.
// ----------------------------------------------------------------------------
module b64d_front
   import b64d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   b64d_req_if.sink      req_ch,
   input  logic          queue_full,
   output logic          push,
   output job_type       job
);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [RES_W-1:0] cnt_ff, cnt_in;
   logic             pad_ff, pad_in;
   logic             err_ff, err_in;
   logic [1:0]       len_ff, len_in;

   logic             accept;
   logic             blank;
   logic             live;
   logic             is_pad;
   logic [1:0]       len_step;
   sextet_type       sx;
   status_type       fin;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // classify the character and work out the job and next state
   always_comb begin
      blank    = is_blank(req_ch.char_in);
      sx       = sextet_of(req_ch.char_in);
      is_pad   = (req_ch.char_in == CHAR_PAD);
      len_step = blank ? len_ff : len_ff + 2'd1;
      live     = !blank && !pad_ff && !err_ff;

      job.bytes[0]    = acc_ff[ACC_W-1 -: BYTE_W];
      job.bytes[1]    = acc_ff[ACC_W-1-BYTE_W -: BYTE_W];
      job.bytes[2]    = {acc_ff[1:0], sx.value};
      job.nres        = '0;
      job.byte_valid  = 1'b1;
      job.last_status = STATUS_OK;
      job.done        = 1'b0;

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      pad_in = pad_ff;
      err_in = err_ff;

      if (live) begin
         if (is_pad) begin
            // padding flushes one byte, two after three sextets
            job.nres = (cnt_ff == 2'd3) ? 2'd2 : 2'd1;
            pad_in   = 1'b1;
         end else if (sx.bad) begin
            job.nres        = 2'd1;
            job.byte_valid  = 1'b0;
            job.last_status = STATUS_BAD_CHAR;
            err_in          = 1'b1;
         end else if (cnt_ff == 2'd3) begin
            job.nres = 2'd3;
            acc_in   = '0;
            cnt_in   = '0;
         end else begin
            case (cnt_ff)
               2'd0:    acc_in = acc_ff | {sx.value, 12'd0};
               2'd1:    acc_in = acc_ff | {6'd0, sx.value, 6'd0};
               default: acc_in = acc_ff | {12'd0, sx.value};
            endcase
            cnt_in = cnt_ff + 2'd1;
         end
      end

      // end of stream: final status rides on the last item
      if (len_step != 2'd0) begin
         fin = STATUS_BAD_LENGTH;
      end else if (err_in) begin
         fin = STATUS_BAD_CHAR;
      end else begin
         fin = STATUS_OK;
      end
      if (req_ch.stream_end) begin
         if (job.nres == '0) begin
            job.nres       = 2'd1;
            job.byte_valid = 1'b0;
         end
         job.last_status = fin;
         job.done        = 1'b1;
      end

      if (!job.byte_valid) begin
         job.bytes = '0;
      end

      len_in = req_ch.stream_end ? 2'd0 : len_step;
      push   = accept && (job.nres != '0);
   end

   // stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         pad_ff <= 1'b0;
         err_ff <= 1'b0;
         len_ff <= '0;
      end else if (accept) begin
         if (req_ch.stream_end) begin
            acc_ff <= '0;
            cnt_ff <= '0;
            pad_ff <= 1'b0;
            err_ff <= 1'b0;
         end else begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_in;
            pad_ff <= pad_in;
            err_ff <= err_in;
         end
         len_ff <= len_in;
      end
   end

endmodule

// ===== rtl/b64d_fifo.sv =====
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module b64d_fifo
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Splits each queued job into result items and drives the output register.
// ----------------------------------------------------------------------------
module b64d_back
   import b64d_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  job_type  head,
   output logic     pop,
   b64d_rsp_if.source rsp_ch
);

   logic [RES_W-1:0]    sel_ff, sel_in;
   logic                valid_ff, valid_in;
   logic [BYTE_W-1:0]   byte_ff;
   logic                bval_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                last_ff;
   logic                done_ff;

   logic                load;
   logic                last;

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.data_byte   = byte_ff;
   assign rsp_ch.byte_valid  = bval_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.run_last    = last_ff;
   assign rsp_ch.stream_done = done_ff;

   // load the next item when the output register is free or draining
   always_comb begin
      load     = !empty && (!valid_ff || rsp_ch.ready);
      last     = (sel_ff == head.nres - 1'b1);
      pop      = load && last;
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         sel_in   = last ? '0 : sel_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head.bytes[sel_ff];
         bval_ff   <= head.byte_valid;
         status_ff <= last ? head.last_status : STATUS_OK;
         last_ff   <= last;
         done_ff   <= last && head.done;
      end
   end

endmodule
